@@ design/piad_pkg.sv @@
`default_nettype none

package piad_pkg;

   // array geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // payload field widths
   localparam int OP_W   = 3;
   localparam int IDX_W  = 7;
   localparam int WORD_W = 32;
   localparam int LEN_W  = 7;
   localparam int ST_W   = 2;

   // common width for index against count compares
   localparam int CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [IDX_W-1:0]         index;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      logic [LEN_W-1:0]         length;
      logic [ST_W-1:0]          status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic shift_start;
      logic shift_step;
      logic wr_new;
      logic rd_idx;
      logic publish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            ok;
      logic            shift_done;
      logic            out_free;
   } stat_type;

endpackage

`default_nettype wire

@@ design/piad_datapath.sv @@
`default_nettype none

module piad_datapath (
   input  logic               clock,
   input  logic               reset,
   input  piad_pkg::req_type  req_data,
   input  piad_pkg::cmd_type  cmd,
   output piad_pkg::stat_type stat,
   output piad_pkg::rsp_type  rsp_data,
   output logic               rsp_valid,
   input  logic               rsp_ready
);
   import piad_pkg::*;

   req_type             req_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [ADDR_W-1:0]   src_ff, src_in;
   logic [ADDR_W-1:0]   dst_ff, dst_in;
   logic                pend_ff, pend_in;
   logic [WORD_W-1:0]   words_ff [DEPTH];
   logic [WORD_W-1:0]   rdata_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                is_ins;
   logic [CMP_W-1:0]    idx_w, cnt_w;
   logic [CNT_W-1:0]    idx_c;
   logic [ADDR_W-1:0]   idx_a;
   logic                range_err, full_err, ok;
   logic [ST_W-1:0]     status;
   logic                rd_en, wr_en;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [WORD_W-1:0]   wr_data;

   // request decode and checks
   always_comb begin
      is_ins = (req_ff.operation == OP_INSERT);
      idx_w  = CMP_W'(req_ff.index);
      cnt_w  = CMP_W'(count_ff);
      idx_c  = CNT_W'(req_ff.index);
      idx_a  = req_ff.index[ADDR_W-1:0];
      full_err  = 1'b0;
      range_err = 1'b0;
      unique case (req_ff.operation)
         OP_APPEND: full_err = (count_ff == CNT_W'(DEPTH));
         OP_INSERT: begin
            range_err = (idx_w > cnt_w);
            full_err  = (count_ff == CNT_W'(DEPTH));
         end
         OP_DELETE, OP_READ: range_err = (idx_w >= cnt_w);
         default: ;
      endcase
      ok = !range_err && !full_err;
      priority if (range_err) begin
         status = ST_RANGE;
      end else if (full_err) begin
         status = ST_FULL;
      end else begin
         status = ST_OK;
      end
   end

   // length after a successful operation
   always_comb begin
      count_in = count_ff;
      if (ok) begin
         unique case (req_ff.operation)
            OP_CLEAR:             count_in = '0;
            OP_APPEND, OP_INSERT: count_in = count_ff + 1'b1;
            OP_DELETE:            count_in = count_ff - 1'b1;
            default: ;
         endcase
      end
   end

   // shift sequencer: read one source per step, write it back on the next step
   always_comb begin
      src_in  = src_ff;
      dst_in  = dst_ff;
      left_in = left_ff;
      pend_in = 1'b0;
      if (cmd.shift_start) begin
         if (is_ins) begin
            src_in  = ADDR_W'(count_ff - 1'b1);
            left_in = count_ff - idx_c;
         end else begin
            src_in  = idx_a + 1'b1;
            left_in = count_ff - idx_c - 1'b1;
         end
      end else if (cmd.shift_step && (left_ff != '0)) begin
         src_in  = is_ins ? src_ff - 1'b1 : src_ff + 1'b1;
         dst_in  = is_ins ? src_ff + 1'b1 : src_ff - 1'b1;
         left_in = left_ff - 1'b1;
         pend_in = 1'b1;
      end
   end

   // memory port selection
   always_comb begin
      rd_en   = (cmd.shift_step && (left_ff != '0)) || cmd.rd_idx;
      rd_addr = cmd.rd_idx ? idx_a : src_ff;
      wr_en   = (cmd.shift_step && pend_ff) || cmd.wr_new;
      wr_addr = cmd.wr_new
                ? ((req_ff.operation == OP_APPEND) ? count_ff[ADDR_W-1:0] : idx_a)
                : dst_ff;
      wr_data = cmd.wr_new ? req_ff.value : rdata_ff;
   end

   // result register
   always_comb begin
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      if (cmd.publish) begin
         rsp_in.read_value = ((req_ff.operation == OP_READ) && ok) ? rdata_ff : '0;
         rsp_in.length     = LEN_W'(count_in);
         rsp_in.status     = status;
         rsp_valid_in      = 1'b1;
      end
   end

   // word store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= words_ff[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      src_ff <= src_in;
      dst_ff <= dst_in;
      rsp_ff <= rsp_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            count_ff <= count_in;
         end
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.op         = req_ff.operation;
   assign stat.ok         = ok;
   assign stat.shift_done = (left_ff == '0) && !pend_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_data        = rsp_ff;
   assign rsp_valid       = rsp_valid_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("stored length beyond array depth");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.publish |=> $stable(count_ff))
      else $error("length changed outside a result publish");

   a_shift_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift_step && pend_ff) |-> (CNT_W'(dst_ff) <= count_ff))
      else $error("shift write beyond the stored words");

endmodule

`default_nettype wire

@@ design/piad_ctrl.sv @@
`default_nettype none

module piad_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  piad_pkg::stat_type stat,
   output piad_pkg::cmd_type  cmd
);
   import piad_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_SHIFT  = 6'b000100,
      S_WRITE  = 6'b001000,
      S_FETCH  = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.ok) begin
               state_in = S_RESP;
            end else begin
               unique case (stat.op)
                  OP_APPEND: state_in = S_WRITE;
                  OP_INSERT, OP_DELETE: begin
                     cmd.shift_start = 1'b1;
                     state_in        = S_SHIFT;
                  end
                  OP_READ: state_in = S_FETCH;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) begin
               state_in = (stat.op == OP_INSERT) ? S_WRITE : S_RESP;
            end
         end
         S_WRITE: begin
            cmd.wr_new = 1'b1;
            state_in   = S_RESP;
         end
         S_FETCH: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // checks
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new transfer taken while an item is in flight");

   a_write_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (stat.ok && (stat.op == OP_APPEND || stat.op == OP_INSERT)))
      else $error("word write for a rejected or non-writing operation");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

endmodule

`default_nettype wire

@@ design/positional_array_insert_delete.sv @@
`default_nettype none

// channel   direction  handshake             payload
// req_      in         req_valid/req_ready   req_data  (operation, index, value)
// rsp_      out        rsp_valid/rsp_ready   rsp_data  (read_value, length, status)
//
// one item at a time; clear, rejected or unknown operations go straight to the result step,
//   append writes the word, read fetches it, delete shifts the later words down and
//   insert shifts them up then writes the new word (one word moved per cycle)
// the word store has one write and one registered read port, which sets the shift rate
// reset clears the length and the control state; stored words are not cleared
// a waiting result stalls only the publish step of the next item

module positional_array_insert_delete (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  piad_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output piad_pkg::rsp_type rsp_data
);
   import piad_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   piad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // word store, length and result register
   piad_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
   import piad_pkg::*;

   // codes with no defined operation
   localparam logic [OP_W-1:0] OP_UNDEF_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_UNDEF_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_HI  = 3'd7;

   localparam int CYCLE_LIMIT      = 1000000;
   localparam int DRAIN_CYCLES     = 100;
   localparam int RANDOM_PER_PHASE = 402;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} burst_mode_type;

   typedef struct {
      req_type rq;
      int      reps;
      bit      typed;
      rsp_type ex;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // array state as the block should hold it
   logic [WORD_W-1:0] model_words [DEPTH];
   int                model_count = 0;

   rsp_type      due_results [$];
   stim_row_type stim_rows [$];
   int           fail_count     = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int unsigned  cycle_count    = 0;

   positional_array_insert_delete i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // apply one operation to the array state and return its result
   function automatic rsp_type apply_array_op(req_type rq);
      rsp_type res;
      int      idx;
      res = '0;
      idx = int'(rq.index);
      case (rq.operation)
         OP_CLEAR: begin
            model_count = 0;
         end
         OP_APPEND: begin
            if (model_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               model_words[model_count] = rq.value;
               model_count++;
            end
         end
         OP_INSERT: begin
            if (idx > model_count) begin
               res.status = ST_RANGE;
            end else if (model_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int i = model_count; i > idx; i--) model_words[i] = model_words[i-1];
               model_words[idx] = rq.value;
               model_count++;
            end
         end
         OP_DELETE: begin
            if (idx >= model_count) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = idx; i + 1 < model_count; i++) model_words[i] = model_words[i+1];
               model_count--;
            end
         end
         OP_READ: begin
            if (idx >= model_count) begin
               res.status = ST_RANGE;
            end else begin
               res.read_value = model_words[idx];
            end
         end
         default: begin
         end
      endcase
      res.length = LEN_W'(model_count);
      return res;
   endfunction

   // random request shaped by the current fill level
   function automatic req_type random_request(burst_mode_type mode);
      req_type rq;
      int      roll;
      int      hi;
      rq   = '0;
      roll = $urandom_range(99);
      case (mode)
         MODE_GROW: begin
            rq.operation = (roll < 45) ? OP_APPEND : (roll < 90) ? OP_INSERT :
                           (roll < 96) ? OP_READ : OP_DELETE;
         end
         MODE_SHRINK: begin
            rq.operation = (roll < 65) ? OP_DELETE : (roll < 85) ? OP_READ :
                           (roll < 95) ? OP_INSERT : OP_APPEND;
         end
         default: begin
            if (roll < 2)       rq.operation = OP_CLEAR;
            else if (roll < 5)  rq.operation = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
            else if (roll < 28) rq.operation = OP_APPEND;
            else if (roll < 52) rq.operation = OP_INSERT;
            else if (roll < 76) rq.operation = OP_DELETE;
            else                rq.operation = OP_READ;
         end
      endcase
      // mostly legal positions, some at the boundary, some anywhere
      hi = (rq.operation == OP_INSERT) ? model_count : model_count - 1;
      if (hi < 0) hi = 0;
      roll = $urandom_range(99);
      if (roll < 80)      rq.index = IDX_W'($urandom_range(hi));
      else if (roll < 92) rq.index = IDX_W'(model_count + $urandom_range(1));
      else                rq.index = IDX_W'($urandom_range(127));
      if ($urandom_range(99) < 10) begin
         case ($urandom_range(3))
            0:       rq.value = 32'sh7fffffff;
            1:       rq.value = 32'sh80000000;
            2:       rq.value = 32'sd0;
            default: rq.value = -32'sd1;
         endcase
      end else begin
         rq.value = $urandom;
      end
      return rq;
   endfunction

   task automatic add_row(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                          logic [WORD_W-1:0] val, int reps, bit typed, rsp_type ex);
      stim_row_type row;
      row.rq    = '{operation: op, index: idx, value: val};
      row.reps  = reps;
      row.typed = typed;
      row.ex    = ex;
      stim_rows.push_back(row);
   endtask

   // one request transfer, with random idle cycles ahead of it
   task automatic send(req_type rq, bit typed, rsp_type ex);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_array_op(rq);
      due_results.push_back(typed ? ex : predicted);
   endtask

   // result channel back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result transfer check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("result transfer with no request pending");
            fail_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value expected %0d got %0d", want.read_value,
                      rsp_data.read_value);
               fail_count++;
            end
            if (rsp_data.length !== want.length) begin
               $error("length expected %0d got %0d", want.length, rsp_data.length);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_data.status);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("positional_array_insert_delete test failed");
      $finish;
   end

   initial begin
      req_type        rq;
      burst_mode_type mode;
      int             roll;
      int             burst;
      int             sent;

      // empty array, bad positions, undefined codes
      add_row(OP_READ, 7'd0, 32'd0, 1, 1'b1, '{32'sd0, 7'd0, ST_RANGE});
      add_row(OP_DELETE, 7'd0, 32'd0, 1, 1'b1, '{32'sd0, 7'd0, ST_RANGE});
      add_row(OP_INSERT, 7'd1, 32'd5, 1, 1'b1, '{32'sd0, 7'd0, ST_RANGE});
      add_row(OP_INSERT, 7'd127, 32'd5, 1, 1'b1, '{32'sd0, 7'd0, ST_RANGE});
      add_row(OP_CLEAR, 7'd0, 32'd0, 1, 1'b1, '{32'sd0, 7'd0, ST_OK});
      add_row(OP_UNDEF_LO, 7'd3, 32'd7, 1, 1'b1, '{32'sd0, 7'd0, ST_OK});
      // fill a few, insert at front and at the end
      add_row(OP_APPEND, 7'd0, 32'h7fffffff, 1, 1'b1, '{32'sd0, 7'd1, ST_OK});
      add_row(OP_APPEND, 7'd0, 32'h80000000, 1, 1'b1, '{32'sd0, 7'd2, ST_OK});
      add_row(OP_INSERT, 7'd0, 32'hffffffff, 1, 1'b1, '{32'sd0, 7'd3, ST_OK});
      add_row(OP_INSERT, 7'd3, 32'h12345678, 1, 1'b1, '{32'sd0, 7'd4, ST_OK});
      add_row(OP_READ, 7'd0, 32'd0, 1, 1'b1, '{-32'sd1, 7'd4, ST_OK});
      add_row(OP_READ, 7'd1, 32'd0, 1, 1'b1, '{32'sh7fffffff, 7'd4, ST_OK});
      add_row(OP_READ, 7'd2, 32'd0, 1, 1'b1, '{32'sh80000000, 7'd4, ST_OK});
      add_row(OP_READ, 7'd3, 32'd0, 1, 1'b1, '{32'sh12345678, 7'd4, ST_OK});
      add_row(OP_READ, 7'd4, 32'd0, 1, 1'b1, '{32'sd0, 7'd4, ST_RANGE});
      add_row(OP_DELETE, 7'd1, 32'd0, 1, 1'b1, '{32'sd0, 7'd3, ST_OK});
      add_row(OP_DELETE, 7'd2, 32'd0, 1, 1'b1, '{32'sd0, 7'd2, ST_OK});
      add_row(OP_UNDEF_HI, 7'd127, 32'hffffffff, 1, 1'b1, '{32'sd0, 7'd2, ST_OK});
      add_row(OP_UNDEF_MID, 7'd0, 32'd0, 1, 1'b1, '{32'sd0, 7'd2, ST_OK});
      add_row(OP_CLEAR, 7'd0, 32'd0, 1, 1'b1, '{32'sd0, 7'd0, ST_OK});
      // full array
      add_row(OP_APPEND, 7'd0, 32'd100, DEPTH, 1'b0, '0);
      add_row(OP_APPEND, 7'd0, 32'd1, 1, 1'b1, '{32'sd0, 7'd64, ST_FULL});
      add_row(OP_INSERT, 7'd64, 32'd1, 1, 1'b1, '{32'sd0, 7'd64, ST_FULL});
      add_row(OP_INSERT, 7'd65, 32'd1, 1, 1'b1, '{32'sd0, 7'd64, ST_RANGE});
      add_row(OP_READ, 7'd63, 32'd0, 1, 1'b1, '{32'sd163, 7'd64, ST_OK});
      add_row(OP_READ, 7'd64, 32'd0, 1, 1'b1, '{32'sd0, 7'd64, ST_RANGE});
      add_row(OP_DELETE, 7'd0, 32'd0, 1, 1'b1, '{32'sd0, 7'd63, ST_OK});
      add_row(OP_INSERT, 7'd10, 32'h55aa55aa, 1, 1'b0, '0);
      add_row(OP_READ, 7'd10, 32'd0, 1, 1'b0, '0);
      add_row(OP_DELETE, 7'd63, 32'd0, 1, 1'b0, '0);
      add_row(OP_CLEAR, 7'd0, 32'd0, 1, 1'b1, '{32'sd0, 7'd0, ST_OK});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (stim_rows[r]) begin
         for (int k = 0; k < stim_rows[r].reps; k++) begin
            rq       = stim_rows[r].rq;
            rq.value = rq.value + k;
            send(rq, stim_rows[r].typed, stim_rows[r].ex);
         end
      end

      // random bursts under three idling profiles
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 31; recv_stall_pct = 87; end
            1:       begin send_idle_pct = 87; recv_stall_pct = 31; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         sent = 0;
         while (sent < RANDOM_PER_PHASE) begin
            roll  = $urandom_range(99);
            mode  = (roll < 45) ? MODE_GROW : (roll < 75) ? MODE_MIXED : MODE_SHRINK;
            burst = $urandom_range(10, 60);
            for (int k = 0; k < burst && sent < RANDOM_PER_PHASE; k++) begin
               send(random_request(mode), 1'b0, '0);
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      // drain
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("positional_array_insert_delete test passed");
      end else begin
         $display("positional_array_insert_delete test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
design/piad_pkg.sv
design/piad_datapath.sv
design/piad_ctrl.sv
design/positional_array_insert_delete.sv
dv/tb.sv
